/* rtl/utf8_line_edit_buffer_defines.svh */
// Assertion macros shared by the line edit buffer RTL.
`ifndef UTF8_LINE_EDIT_BUFFER_DEFINES_SVH
`define UTF8_LINE_EDIT_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ULE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ULE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ule_pkg.sv */
package ule_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BACK,
      ST_FWD,
      ST_HOME,
      ST_TOEND,
      ST_INSERT,
      ST_SEEK,
      ST_RETURN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   localparam logic [8:0] KEY_BACKSPACE = 9'd14;
   localparam logic [8:0] KEY_LEFT      = 9'd331;
   localparam logic [8:0] KEY_RIGHT     = 9'd333;
   localparam logic [8:0] KEY_HOME      = 9'd327;
   localparam logic [8:0] KEY_END       = 9'd335;

   localparam logic [15:0] CP_TWO_BYTES   = 16'h0080;
   localparam logic [15:0] CP_THREE_BYTES = 16'h0800;

endpackage

/* rtl/ule_cell.sv */
module ule_cell (
   input  logic                   clock,
   input  ule_pkg::stack_ctl_type ctl,
   input  logic [7:0]             from_above,
   input  logic [7:0]             from_below,
   output logic [7:0]             cell_byte
);

   logic [7:0] byte_ff;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         byte_ff <= from_above;
      end else if (ctl.pop) begin
         byte_ff <= from_below;
      end
   end

   assign cell_byte = byte_ff;

endmodule

/* rtl/ule_stack.sv */
module ule_stack #(
   parameter int DEPTH = 256
) (
   input  logic                   clock,
   input  ule_pkg::stack_ctl_type ctl,
   input  logic [7:0]             push_byte,
   output logic [1:0][7:0]        head
);

   logic [DEPTH-1:0][7:0] cells;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] above;
      logic [7:0] below;

      if (i == 0) begin : g_top
         assign above = push_byte;
      end else begin : g_inner
         assign above = cells[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign below = 8'h00;
      end else begin : g_upper
         assign below = cells[i+1];
      end

      ule_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .cell_byte  (cells[i])
      );
   end

   assign head[0] = cells[0];
   assign head[1] = cells[1];

endmodule

/* rtl/utf8_line_edit_buffer.sv */
// Clear, unknown keys and dropped inserts go straight to the response; an insert pushes
// its encoded bytes one at a time. Backspace, left and right step over the bytes of one
// character; home and end walk the caret to the edge. A read walks the caret to the index and back.
// One transaction is worked at a time; the next is accepted the cycle after the response
// register loads.
// Synchronous active-high reset empties the buffer and sets the caret to zero.
`include "utf8_line_edit_buffer_defines.svh"

module utf8_line_edit_buffer #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_scancode,
   input  logic [15:0] req_codepoint,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_handled,
   output logic        rsp_overflow,
   output logic [8:0]  rsp_caret_out,
   output logic [8:0]  rsp_length_out,
   output logic [7:0]  rsp_read_byte
);

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam int OW = (CW > 9) ? CW : 9;
   localparam logic [CW:0] CAP = (CW + 1)'(BUFFER_BYTES);

   ule_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   caret_ff, caret_in;
   logic [CW-1:0]   length_ff, length_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   orig_ff, orig_in;
   logic            del_ff, del_in;
   logic [1:0]      steps_ff, steps_in;
   logic [2:0][7:0] ins_bytes_ff, ins_bytes_in;
   logic [1:0]      ins_cnt_ff, ins_cnt_in;
   logic            handled_ff, handled_in;
   logic            overflow_ff, overflow_in;
   logic [7:0]      rbyte_ff, rbyte_in;

   logic            rsp_valid_ff;
   logic            rsp_handled_ff;
   logic            rsp_overflow_ff;
   logic [8:0]      rsp_caret_ff;
   logic [8:0]      rsp_length_ff;
   logic [7:0]      rsp_byte_ff;

   ule_pkg::stack_ctl_type lctl, rctl;
   logic [7:0]      l_push;
   logic [1:0][7:0] l_head, r_head;

   logic            accept;
   logic            rsp_load;
   logic [2:0][7:0] enc;
   logic [1:0]      enc_len;
   logic [CW:0]     grown;
   logic            fits;
   logic [XW-1:0]   idx_wide, len_wide;
   logic            in_range;
   logic [1:0]      fwd_steps;
   logic            back_stop;
   logic            fwd_stop;
   logic [CW-1:0]   room;
   logic            move_left, move_right, pop_left, push_ins;
   logic [OW-1:0]   caret_wide, length_wide;

   assign req_ready = (state_ff == ule_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ule_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      enc = '0;
      if (req_codepoint < ule_pkg::CP_TWO_BYTES) begin
         enc[0]  = req_codepoint[7:0];
         enc_len = 2'd1;
      end else if (req_codepoint < ule_pkg::CP_THREE_BYTES) begin
         enc[0]  = {3'b110, req_codepoint[10:6]};
         enc[1]  = {2'b10, req_codepoint[5:0]};
         enc_len = 2'd2;
      end else begin
         enc[0]  = {4'b1110, req_codepoint[15:12]};
         enc[1]  = {2'b10, req_codepoint[11:6]};
         enc[2]  = {2'b10, req_codepoint[5:0]};
         enc_len = 2'd3;
      end
   end

   assign grown    = {1'b0, length_ff} + (CW + 1)'(enc_len);
   assign fits     = (grown <= CAP);
   assign idx_wide = XW'(req_read_index);
   assign len_wide = XW'(length_ff);
   assign in_range = (idx_wide < len_wide);
   assign room     = length_ff - caret_ff;

   always_comb begin
      if (r_head[0][7:5] == 3'b111) begin
         fwd_steps = 2'd3;
      end else if (r_head[0][7:5] == 3'b110) begin
         fwd_steps = 2'd2;
      end else begin
         fwd_steps = 2'd1;
      end
   end

   // A backward scan stops after a lead byte or an ASCII byte, at the start of
   // the buffer, or when the byte below is ASCII.
   assign back_stop = !l_head[0][7] || (l_head[0][7:6] == 2'b11)
                      || (caret_ff == CW'(1)) || !l_head[1][7];
   assign fwd_stop  = (steps_ff == 2'd1) || (room == CW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ule_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  ule_pkg::KIND_KEY: begin
                     unique case (req_scancode)
                        ule_pkg::KEY_BACKSPACE, ule_pkg::KEY_LEFT: begin
                           state_in = (caret_ff != '0) ? ule_pkg::ST_BACK
                                                       : ule_pkg::ST_DONE;
                        end
                        ule_pkg::KEY_RIGHT: begin
                           state_in = (caret_ff != length_ff) ? ule_pkg::ST_FWD
                                                              : ule_pkg::ST_DONE;
                        end
                        ule_pkg::KEY_HOME: state_in = ule_pkg::ST_HOME;
                        ule_pkg::KEY_END:  state_in = ule_pkg::ST_TOEND;
                        default:           state_in = ule_pkg::ST_DONE;
                     endcase
                  end
                  ule_pkg::KIND_INSERT: begin
                     state_in = fits ? ule_pkg::ST_INSERT : ule_pkg::ST_DONE;
                  end
                  ule_pkg::KIND_CLEAR: state_in = ule_pkg::ST_DONE;
                  ule_pkg::KIND_READ: begin
                     state_in = in_range ? ule_pkg::ST_SEEK : ule_pkg::ST_DONE;
                  end
                  default: state_in = ule_pkg::ST_DONE;
               endcase
            end
         end
         ule_pkg::ST_BACK: begin
            if (back_stop) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_FWD: begin
            if (fwd_stop) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_HOME: begin
            if (caret_ff == '0) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_TOEND: begin
            if (caret_ff == length_ff) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_INSERT: begin
            if (ins_cnt_ff == 2'd1) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_SEEK: begin
            if (caret_ff == idx_ff) state_in = ule_pkg::ST_RETURN;
         end
         ule_pkg::ST_RETURN: begin
            if (caret_ff == orig_ff) state_in = ule_pkg::ST_DONE;
         end
         ule_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ule_pkg::ST_IDLE;
         end
         default: state_in = ule_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      move_left    = 1'b0;
      move_right   = 1'b0;
      pop_left     = 1'b0;
      push_ins     = 1'b0;
      caret_in     = caret_ff;
      length_in    = length_ff;
      idx_in       = idx_ff;
      orig_in      = orig_ff;
      del_in       = del_ff;
      steps_in     = steps_ff;
      ins_bytes_in = ins_bytes_ff;
      ins_cnt_in   = ins_cnt_ff;
      handled_in   = handled_ff;
      overflow_in  = overflow_ff;
      rbyte_in     = rbyte_ff;

      unique case (state_ff)
         ule_pkg::ST_IDLE: begin
            if (accept) begin
               handled_in   = 1'b1;
               overflow_in  = 1'b0;
               rbyte_in     = 8'h00;
               del_in       = (req_scancode == ule_pkg::KEY_BACKSPACE);
               steps_in     = fwd_steps;
               ins_bytes_in = enc;
               ins_cnt_in   = enc_len;
               idx_in       = CW'(req_read_index);
               orig_in      = caret_ff;
               unique case (req_kind)
                  ule_pkg::KIND_KEY: begin
                     unique case (req_scancode)
                        ule_pkg::KEY_BACKSPACE, ule_pkg::KEY_LEFT, ule_pkg::KEY_RIGHT,
                        ule_pkg::KEY_HOME, ule_pkg::KEY_END: handled_in = 1'b1;
                        default: handled_in = 1'b0;
                     endcase
                  end
                  ule_pkg::KIND_INSERT: begin
                     handled_in  = fits;
                     overflow_in = !fits;
                  end
                  ule_pkg::KIND_CLEAR: begin
                     caret_in  = '0;
                     length_in = '0;
                  end
                  ule_pkg::KIND_READ: handled_in = 1'b1;
                  default: handled_in = 1'b1;
               endcase
            end
         end
         ule_pkg::ST_BACK: begin
            if (del_ff) begin
               pop_left = 1'b1;
            end else begin
               move_left = 1'b1;
            end
         end
         ule_pkg::ST_FWD: begin
            move_right = 1'b1;
            steps_in   = steps_ff - 2'd1;
         end
         ule_pkg::ST_HOME: begin
            move_left = (caret_ff != '0);
         end
         ule_pkg::ST_TOEND: begin
            move_right = (caret_ff != length_ff);
         end
         ule_pkg::ST_INSERT: begin
            push_ins     = 1'b1;
            ins_bytes_in = {8'h00, ins_bytes_ff[2], ins_bytes_ff[1]};
            ins_cnt_in   = ins_cnt_ff - 2'd1;
         end
         ule_pkg::ST_SEEK: begin
            move_left  = (caret_ff > idx_ff);
            move_right = (caret_ff < idx_ff);
            if (caret_ff == idx_ff) rbyte_in = r_head[0];
         end
         ule_pkg::ST_RETURN: begin
            move_left  = (caret_ff > orig_ff);
            move_right = (caret_ff < orig_ff);
         end
         ule_pkg::ST_DONE: begin
            move_left = 1'b0;
         end
         default: begin
            move_left = 1'b0;
         end
      endcase

      if (move_right || push_ins) begin
         caret_in = caret_ff + CW'(1);
      end else if (move_left || pop_left) begin
         caret_in = caret_ff - CW'(1);
      end
      if (push_ins) begin
         length_in = length_ff + CW'(1);
      end else if (pop_left) begin
         length_in = length_ff - CW'(1);
      end
   end

   assign lctl.push = move_right || push_ins;
   assign lctl.pop  = move_left || pop_left;
   assign rctl.push = move_left;
   assign rctl.pop  = move_right;
   assign l_push    = push_ins ? ins_bytes_ff[0] : r_head[0];

   ule_stack #(
      .DEPTH (BUFFER_BYTES)
   ) u_left (
      .clock     (clock),
      .ctl       (lctl),
      .push_byte (l_push),
      .head      (l_head)
   );

   ule_stack #(
      .DEPTH (BUFFER_BYTES)
   ) u_right (
      .clock     (clock),
      .ctl       (rctl),
      .push_byte (l_head[0]),
      .head      (r_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ule_pkg::ST_IDLE;
         caret_ff  <= '0;
         length_ff <= '0;
      end else begin
         state_ff  <= state_in;
         caret_ff  <= caret_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      orig_ff      <= orig_in;
      del_ff       <= del_in;
      steps_ff     <= steps_in;
      ins_bytes_ff <= ins_bytes_in;
      ins_cnt_ff   <= ins_cnt_in;
      handled_ff   <= handled_in;
      overflow_ff  <= overflow_in;
      rbyte_ff     <= rbyte_in;
   end

   assign caret_wide  = OW'(caret_ff);
   assign length_wide = OW'(length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_handled_ff  <= handled_ff;
         rsp_overflow_ff <= overflow_ff;
         rsp_caret_ff    <= caret_wide[8:0];
         rsp_length_ff   <= length_wide[8:0];
         rsp_byte_ff     <= rbyte_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handled    = rsp_handled_ff;
   assign rsp_overflow   = rsp_overflow_ff;
   assign rsp_caret_out  = rsp_caret_ff;
   assign rsp_length_out = rsp_length_ff;
   assign rsp_read_byte  = rsp_byte_ff;

   `ULE_ASSERT_SAME(a_caret_in_text, clock, reset, 1'b1, caret_ff <= length_ff, "Caret is beyond the text length.")
   `ULE_ASSERT_SAME(a_length_cap, clock, reset, 1'b1, {1'b0, length_ff} <= CAP, "Text length exceeds the buffer size.")
   `ULE_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ule_pkg::ST_IDLE, "Accepted transaction did not start work.")
   `ULE_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ule_pkg::ST_DONE, "Response raised outside the completion state.")
   `ULE_ASSERT_SAME(a_back_nonzero, clock, reset, state_ff == ule_pkg::ST_BACK, caret_ff != '0, "Backward scan started at the start of the text.")

endmodule

/* bench/line_edit_checker.sv */
module line_edit_checker #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_scancode,
   input  logic [15:0] req_codepoint,
   input  logic [7:0]  req_read_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_handled,
   input  logic        rsp_overflow,
   input  logic [8:0]  rsp_caret_out,
   input  logic [8:0]  rsp_length_out,
   input  logic [7:0]  rsp_read_byte,
   output int          fault_count,
   output int          open_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       handled;
      logic       overflow;
      logic [8:0] caret;
      logic [8:0] length;
      logic [7:0] read_byte;
   } edit_result_type;

   logic [7:0]      text_mem [0:BUFFER_BYTES-1];
   logic [8:0]      caret_pos;
   logic [8:0]      text_len;
   edit_result_type pending_edits [$];
   int              rsp_seen;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: response %0d %s: got %0d, expected %0d",
               $realtime, rsp_seen, what, got, want);
      fault_count++;
   endtask

   // Finds the lead byte of the sequence that ends just before pos.
   function automatic int lead_index_before(input int pos);
      int p;
      p = pos - 1;
      if (!text_mem[p][7]) return p;
      while (1) begin
         if (text_mem[p][7:6] == 2'b11) return p;
         if (p == 0) return 0;
         if (!text_mem[p-1][7]) return p;
         p--;
      end
   endfunction

   function automatic edit_result_type edit_step(input logic [1:0] kind,
                                                 input logic [8:0] code,
                                                 input logic [15:0] cp,
                                                 input logic [7:0] idx);
      edit_result_type res;
      logic [7:0]      enc [0:2];
      logic [7:0]      lead;
      int              n;
      int              start;
      int              span;
      res = '0;
      if (caret_pos > text_len) caret_pos = text_len;
      case (kind)
         ule_pkg::KIND_KEY: begin
            res.handled = 1'b1;
            if (code == ule_pkg::KEY_BACKSPACE) begin
               if (caret_pos != 0) begin
                  start = lead_index_before(int'(caret_pos));
                  span = int'(caret_pos) - start;
                  for (int i = int'(caret_pos); i < int'(text_len); i++) begin
                     text_mem[i - span] = text_mem[i];
                  end
                  text_len = 9'(int'(text_len) - span);
                  caret_pos = 9'(start);
               end
            end else if (code == ule_pkg::KEY_LEFT) begin
               if (caret_pos != 0) caret_pos = 9'(lead_index_before(int'(caret_pos)));
            end else if (code == ule_pkg::KEY_RIGHT) begin
               if (caret_pos < text_len) begin
                  lead = text_mem[caret_pos];
                  if (lead[7:5] == 3'b111) n = 3;
                  else if (lead[7:5] == 3'b110) n = 2;
                  else n = 1;
                  if (int'(caret_pos) + n > int'(text_len)) caret_pos = text_len;
                  else caret_pos = 9'(int'(caret_pos) + n);
               end
            end else if (code == ule_pkg::KEY_HOME) begin
               caret_pos = '0;
            end else if (code == ule_pkg::KEY_END) begin
               caret_pos = text_len;
            end else begin
               res.handled = 1'b0;
            end
         end
         ule_pkg::KIND_INSERT: begin
            if (cp < ule_pkg::CP_TWO_BYTES) begin
               enc[0] = cp[7:0];
               n = 1;
            end else if (cp < ule_pkg::CP_THREE_BYTES) begin
               enc[0] = {3'b110, cp[10:6]};
               enc[1] = {2'b10, cp[5:0]};
               n = 2;
            end else begin
               enc[0] = {4'b1110, cp[15:12]};
               enc[1] = {2'b10, cp[11:6]};
               enc[2] = {2'b10, cp[5:0]};
               n = 3;
            end
            if (int'(text_len) + n > BUFFER_BYTES) begin
               res.overflow = 1'b1;
            end else begin
               for (int i = int'(text_len) - 1; i >= int'(caret_pos); i--) begin
                  text_mem[i + n] = text_mem[i];
               end
               for (int i = 0; i < n; i++) begin
                  text_mem[int'(caret_pos) + i] = enc[i];
               end
               text_len = 9'(int'(text_len) + n);
               caret_pos = 9'(int'(caret_pos) + n);
               res.handled = 1'b1;
            end
         end
         ule_pkg::KIND_CLEAR: begin
            text_len = '0;
            caret_pos = '0;
            res.handled = 1'b1;
         end
         default: begin
            if (idx < text_len) res.read_byte = text_mem[idx];
            res.handled = 1'b1;
         end
      endcase
      res.caret = caret_pos;
      res.length = text_len;
      return res;
   endfunction

   always @(posedge clock) begin
      edit_result_type want;
      if (reset) begin
         caret_pos = '0;
         text_len = '0;
         pending_edits.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (pending_edits.size() == 0) begin
               report_mismatch("arrived with no transaction waiting", 1, 0);
            end else begin
               want = pending_edits.pop_front();
               if (rsp_handled !== want.handled)
                  report_mismatch("handled", int'(rsp_handled), int'(want.handled));
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", int'(rsp_overflow), int'(want.overflow));
               if (rsp_caret_out !== want.caret)
                  report_mismatch("caret", int'(rsp_caret_out), int'(want.caret));
               if (rsp_length_out !== want.length)
                  report_mismatch("length", int'(rsp_length_out), int'(want.length));
               if (rsp_read_byte !== want.read_byte)
                  report_mismatch("read byte", int'(rsp_read_byte), int'(want.read_byte));
            end
         end
         if (req_valid && req_ready) begin
            pending_edits.push_back(edit_step(req_kind, req_scancode, req_codepoint,
                                              req_read_index));
         end
      end
      open_results = pending_edits.size();
   end

endmodule

/* bench/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUFFER_BYTES  = 256;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int DRAIN_CYCLES  = 2 * BUFFER_BYTES + 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [8:0]  req_scancode;
   logic [15:0] req_codepoint;
   logic [7:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_handled;
   logic        rsp_overflow;
   logic [8:0]  rsp_caret_out;
   logic [8:0]  rsp_length_out;
   logic [7:0]  rsp_read_byte;

   int fault_count;
   int open_results;
   int sent_items;
   int rsp_taken;
   int quiet_cycles;
   bit held_off;

   utf8_line_edit_buffer #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_scancode  (req_scancode),
      .req_codepoint (req_codepoint),
      .req_read_index(req_read_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_handled   (rsp_handled),
      .rsp_overflow  (rsp_overflow),
      .rsp_caret_out (rsp_caret_out),
      .rsp_length_out(rsp_length_out),
      .rsp_read_byte (rsp_read_byte)
   );

   line_edit_checker #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_scancode  (req_scancode),
      .req_codepoint (req_codepoint),
      .req_read_index(req_read_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_handled   (rsp_handled),
      .rsp_overflow  (rsp_overflow),
      .rsp_caret_out (rsp_caret_out),
      .rsp_length_out(rsp_length_out),
      .rsp_read_byte (rsp_read_byte),
      .fault_count   (fault_count),
      .open_results  (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) rsp_taken++;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // The receiver stalls at random, holds off once for a long stretch so the
   // block backs up, and stays ready throughout a later window.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && rsp_taken >= 300) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (rsp_taken >= 700 && rsp_taken < 900) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(99) >= 20);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_edit(input logic [1:0] kind, input logic [8:0] code,
                            input logic [15:0] cp, input logic [7:0] idx);
      bit calm;
      calm = (sent_items >= 250 && sent_items < 600);
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_scancode   <= code;
      req_codepoint  <= cp;
      req_read_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic random_edit(input int insert_pct);
      logic [1:0]  kind;
      logic [8:0]  code;
      logic [15:0] cp;
      logic [7:0]  idx;
      int          roll;
      int          pick;
      code = 9'($urandom_range(511));
      cp   = 16'($urandom_range(65535));
      idx  = 8'($urandom_range(255));
      roll = int'($urandom_range(99));
      if (roll < insert_pct) begin
         kind = ule_pkg::KIND_INSERT;
         pick = int'($urandom_range(2));
         if (pick == 0) begin
            cp = 16'($urandom_range(ule_pkg::CP_TWO_BYTES - 1));
         end else if (pick == 1) begin
            cp = 16'($urandom_range(ule_pkg::CP_THREE_BYTES - 1, ule_pkg::CP_TWO_BYTES));
         end else begin
            cp = 16'($urandom_range(16'hFFFF, ule_pkg::CP_THREE_BYTES));
         end
      end else if (roll < insert_pct + 8) begin
         kind = ule_pkg::KIND_READ;
         if ($urandom_range(1) == 1) idx = 8'($urandom_range(63));
      end else if (roll < 99) begin
         kind = ule_pkg::KIND_KEY;
         pick = int'($urandom_range(99));
         if (pick < 25) code = ule_pkg::KEY_BACKSPACE;
         else if (pick < 45) code = ule_pkg::KEY_LEFT;
         else if (pick < 65) code = ule_pkg::KEY_RIGHT;
         else if (pick < 75) code = ule_pkg::KEY_HOME;
         else if (pick < 85) code = ule_pkg::KEY_END;
      end else begin
         kind = ule_pkg::KIND_CLEAR;
      end
      send_edit(kind, code, cp, idx);
   endtask

   initial begin
      int  insert_pct;
      bit  drained;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = ule_pkg::KIND_KEY;
      req_scancode   = '0;
      req_codepoint  = '0;
      req_read_index = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_BACKSPACE, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_LEFT, 16'hFFFF, 8'hFF);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_RIGHT, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, 9'h000, 16'hFFFF, 8'hFF);
      send_edit(ule_pkg::KIND_KEY, 9'h1FF, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_INSERT, 9'h1FF, 16'h0000, 8'hFF);
      send_edit(ule_pkg::KIND_INSERT, 9'h000, ule_pkg::CP_TWO_BYTES - 16'd1, 8'h00);
      send_edit(ule_pkg::KIND_INSERT, 9'h1FF, ule_pkg::CP_TWO_BYTES, 8'hFF);
      send_edit(ule_pkg::KIND_INSERT, 9'h000, ule_pkg::CP_THREE_BYTES - 16'd1, 8'h00);
      send_edit(ule_pkg::KIND_INSERT, 9'h1FF, ule_pkg::CP_THREE_BYTES, 8'hFF);
      send_edit(ule_pkg::KIND_INSERT, 9'h000, 16'hFFFF, 8'h00);
      send_edit(ule_pkg::KIND_READ, 9'h1FF, 16'hFFFF, 8'h00);
      send_edit(ule_pkg::KIND_READ, 9'h000, 16'h0000, 8'hFF);
      send_edit(ule_pkg::KIND_READ, 9'h1FF, 16'h0000, 8'h07);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_HOME, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_RIGHT, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_RIGHT, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_RIGHT, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_LEFT, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_INSERT, 9'h000, 16'h00E9, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_BACKSPACE, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_END, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_KEY, ule_pkg::KEY_BACKSPACE, 16'h0000, 8'h00);
      send_edit(ule_pkg::KIND_CLEAR, 9'h1FF, 16'hFFFF, 8'hFF);
      send_edit(ule_pkg::KIND_READ, 9'h000, 16'h0000, 8'h00);

      // Every third segment fills toward overflow and the others mix editing; every fourth starts with a clear.
      drained = 1'b0;
      for (int seg = 0; seg < RANDOM_ITEMS / 100; seg++) begin
         if (seg % 4 == 3) begin
            send_edit(ule_pkg::KIND_CLEAR, 9'($urandom_range(511)),
                      16'($urandom_range(65535)), 8'($urandom_range(255)));
         end
         insert_pct = (seg % 3 == 0) ? 80 : int'($urandom_range(65, 40));
         for (int k = 0; k < 100; k++) begin
            if (!drained && sent_items >= 800) begin
               drained = 1'b1;
               req_valid <= 1'b0;
               @(negedge clock);
               while (open_results != 0) @(negedge clock);
            end
            random_edit(insert_pct);
         end
      end

      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
